>>> rtl/tfs_pkg.sv
// Shared types, op codes and the binary64 narrowing function of the typed field serializer.
// No dependencies.
package tfs_pkg;

    // Field type codes carried in op.
    localparam logic [3:0] OP_S8  = 4'd0;
    localparam logic [3:0] OP_U8  = 4'd1;
    localparam logic [3:0] OP_S16 = 4'd2;
    localparam logic [3:0] OP_U16 = 4'd3;
    localparam logic [3:0] OP_S32 = 4'd4;
    localparam logic [3:0] OP_U32 = 4'd5;
    localparam logic [3:0] OP_S64 = 4'd6;
    localparam logic [3:0] OP_U64 = 4'd7;
    localparam logic [3:0] OP_F16 = 4'd8;
    localparam logic [3:0] OP_F32 = 4'd9;
    localparam logic [3:0] OP_F64 = 4'd10;

    // A field word ready to serialize.
    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes_m1;
        logic        le;
        logic        err;
    } field_t;

    // Narrows a binary64 pattern whose fraction is already normalized.
    // frac is the 52-bit fraction F, e the unbiased exponent.
    // Returns {ok, word}.
    function automatic logic [64:0] narrow(input logic sign, input logic [51:0] frac,
                                           input logic signed [12:0] e, input logic [1:0] sel);
        logic [63:0] a;
        logic [63:0] b;
        logic [117:0] t;
        logic [63:0] sig;
        logic signed [13:0] be;
        logic [63:0] w;
        logic ok;
        int unsigned n;
        int unsigned s;
        int unsigned eb;
        begin
            unique case (sel)
                2'd0:    begin n = 10; eb = 5;  end
                2'd1:    begin n = 23; eb = 8;  end
                default: begin n = 52; eb = 11; end
            endcase
            s   = 52 - n;
            a   = 64'(frac) >> s;
            b   = 64'(frac) & ((64'd1 << s) - 64'd1);
            t   = (118'(b) << (n + 1)) + 118'(frac);
            sig = a + 64'(t >> 53);
            be  = 14'(e) + 14'((1 << (eb - 1)) - 1);
            ok  = ((sig >> n) == 64'd0) && (be >= 0) && (be <= 14'((1 << eb) - 1));
            w   = (64'(sign) << (n + eb)) | (64'(be) << n) | sig;
            narrow = {ok, ok ? w : 64'd0};
        end
    endfunction

endpackage

>>> rtl/tfs_convert.sv
// Input register stage and field conversion of the typed field serializer.
// Depends on tfs_pkg.
module tfs_convert (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [3:0]      op,
    input  logic            little_endian,
    input  logic [63:0]     value,
    output logic            fld_valid,
    input  logic            fld_ready,
    output tfs_pkg::field_t fld
);
    import tfs_pkg::*;

    logic        v_reg;
    logic [3:0]  op_reg;
    logic        le_reg;
    logic [63:0] val_reg;
    logic [51:0] frac;
    logic signed [12:0] e;
    logic [5:0]  p;
    logic [64:0] nres;
    logic        zero;
    logic        nonfin;
    logic        known;

    // Accept when the register is empty or drains this cycle.
    assign in_ready = !v_reg || fld_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (in_ready)
            v_reg <= in_valid && (op <= OP_F64);
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            op_reg  <= op;
            le_reg  <= little_endian;
            val_reg <= value;
        end
    end

    // Leading one of a subnormal fraction.
    always_comb
    begin
        p = 6'd0;
        for (int i = 1; i < 52; i++)
            if (val_reg[i])
                p = 6'(i);
    end

    // Normalize, then narrow to the target width.
    always_comb
    begin
        zero   = (val_reg[62:0] == 63'd0);
        nonfin = (val_reg[62:52] == 11'h7FF);
        if (val_reg[62:52] == 11'd0)
        begin
            frac = 52'(val_reg[51:0] << (6'd52 - p));
            e    = 13'(p) - 13'sd1074;
        end
        else
        begin
            frac = val_reg[51:0];
            e    = 13'(val_reg[62:52]) - 13'sd1023;
        end
        nres = narrow(val_reg[63], frac, e, (op_reg == OP_F16) ? 2'd0 :
                      (op_reg == OP_F32) ? 2'd1 : 2'd2);
        known     = 1'b1;
        fld.le    = le_reg;
        fld.err   = 1'b0;
        fld.word  = val_reg;
        case (op_reg)
            OP_S8, OP_U8:   fld.nbytes_m1 = 4'd0;
            OP_S16, OP_U16: fld.nbytes_m1 = 4'd1;
            OP_S32, OP_U32: fld.nbytes_m1 = 4'd3;
            OP_S64, OP_U64: fld.nbytes_m1 = 4'd7;
            default:
            begin
                fld.nbytes_m1 = (op_reg == OP_F16) ? 4'd1 : (op_reg == OP_F32) ? 4'd3 : 4'd7;
                if (zero)
                    fld.word = 64'd0;
                else if (nonfin || !nres[64])
                begin
                    fld.word = 64'd0;
                    fld.err  = 1'b1;
                end
                else
                    fld.word = nres[63:0];
                known = (op_reg <= OP_F64);
            end
        endcase
    end

    assign fld_valid = v_reg && known;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        fld_valid && fld.err |-> fld.word == 64'd0) else $error("error word not zero");
    a_int_ok: assert property (@(posedge clk) disable iff (!rst_n)
        fld_valid && op_reg < OP_F16 |-> !fld.err) else $error("integer flagged");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fld_valid && !fld_ready |=> fld_valid && $stable(op_reg)) else $error("field lost");
`endif
endmodule

>>> rtl/tfs_emit.sv
// Byte emitter of the typed field serializer: walks the field word one byte per cycle while m_ready is high.
// Depends on tfs_pkg.
module tfs_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fld_valid,
    output logic            fld_ready,
    input  tfs_pkg::field_t fld,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [7:0]      out_byte,
    output logic            last,
    output logic            range_error
);
    import tfs_pkg::*;

    logic        busy_reg;
    field_t      cur_reg;
    logic [2:0]  k_reg;
    logic [2:0]  pos;
    logic        fin;

    // Take a new field when idle or when the final byte leaves now.
    assign fin       = busy_reg && m_ready && (4'(k_reg) == cur_reg.nbytes_m1);
    assign fld_ready = !busy_reg || fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            k_reg    <= 3'd0;
        end
        else if (fld_ready)
        begin
            busy_reg <= fld_valid;
            k_reg    <= 3'd0;
        end
        else if (m_ready)
            k_reg <= k_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (fld_ready && fld_valid)
            cur_reg <= fld;
    end

    // Byte select by order.
    assign pos         = cur_reg.le ? k_reg : (3'(cur_reg.nbytes_m1) - k_reg);
    assign out_byte    = cur_reg.word[8*pos +: 8];
    assign last        = (4'(k_reg) == cur_reg.nbytes_m1);
    assign range_error = cur_reg.err;
    assign m_valid     = busy_reg;

`ifndef SYNTHESIS
    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> 4'(k_reg) <= cur_reg.nbytes_m1) else $error("byte index overrun");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid && !m_ready |=> $stable(k_reg)) else $error("index moved in stall");
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        fld_ready && fld_valid |=> busy_reg && k_reg == 3'd0) else $error("field not taken");
`endif
endmodule

>>> rtl/typed_field_serializer.sv
// Top level of the typed field serializer.
// Depends on tfs_pkg, tfs_convert and tfs_emit.
//
// Usage: s_axis carries one typed field per transaction; tuser holds op in
// bits 3:0, tdata holds little_endian in bit 0 and value in bits 64:1.
// m_axis returns the field's bytes, one per transaction, with tlast on the
// final byte and tuser = range_error when a float could not be narrowed
// (bytes then zero). Ops 11 to 15 are dropped with no output.
// The input register of tfs_convert holds the field; tfs_emit then loads
// it and drives its bytes, one per cycle while m_axis_tready is high, of
// 1, 2, 4 or 8 per field; the next field loads as the last byte leaves.
// Reset clears both stages; no output is valid after reset.
// When the receiver stalls, the current byte holds and one further field
// waits in the input register before s_axis_tready falls.
module typed_field_serializer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // little_endian[0], value[64:1]
    input  logic [3:0]  s_axis_tuser,  // op[3:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
    output logic        m_axis_tlast,
    output logic        m_axis_tuser   // range_error[0]
);
    import tfs_pkg::*;

    logic   fld_valid;
    logic   fld_ready;
    field_t fld;

    tfs_convert u_convert (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .op            (s_axis_tuser),
        .little_endian (s_axis_tdata[0]),
        .value         (s_axis_tdata[64:1]),
        .fld_valid     (fld_valid),
        .fld_ready     (fld_ready),
        .fld           (fld)
    );

    tfs_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .fld_valid   (fld_valid),
        .fld_ready   (fld_ready),
        .fld         (fld),
        .m_valid     (m_axis_tvalid),
        .m_ready     (m_axis_tready),
        .out_byte    (m_axis_tdata),
        .last        (m_axis_tlast),
        .range_error (m_axis_tuser)
    );
endmodule

>>> test/typed_field_serializer_tb.sv
// Self-checking testbench of the typed field serializer.
// Depends on tfs_pkg and typed_field_serializer; predicts bytes from hand-typed words or its own narrowing.
module typed_field_serializer_tb;
    import tfs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [63:0] FRAC_MASK = 64'h000F_FFFF_FFFF_FFFF;

    // One serialized byte as it should leave m_axis.
    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       err;
    } byte_exp_t;

    // One directed row; known rows carry the packed word typed in by hand.
    typedef struct {
        logic [3:0]  op;
        logic        le;
        logic [63:0] value;
        bit          known;
        logic [63:0] word;
        logic        err;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;  // little_endian[0], value[64:1]
    logic [3:0]  s_axis_tuser;  // op[3:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;  // out_byte[7:0]
    logic        m_axis_tlast;
    logic        m_axis_tuser;  // range_error[0]

    byte_exp_t pending_bytes[$];
    int idle_pct;
    int stall_pct;
    bit hold_req;
    int hold_cnt;
    int errors;
    int fields_sent;
    int bytes_seen;
    int range_errs_seen;
    int quiet_cycles;

    typed_field_serializer dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tuser(m_axis_tuser)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Narrows a binary64 pattern to a word of the given width; returns 0 when not representable.
    function automatic bit narrow_to_word(input logic [63:0] pat, input int width, input int ebits,
                                          output logic [63:0] word);
        logic [63:0] mant;
        logic [63:0] frac;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] sig;
        longint expo;
        longint biased;
        int fbits;
        int shift;
        int top;
        begin
            word  = 64'd0;
            fbits = width - ebits - 1;
            shift = 52 - fbits;
            mant  = pat & FRAC_MASK;
            if (pat[62:52] == 11'd0 && mant == 64'd0)
                return 1'b1;
            if (pat[62:52] == 11'h7FF)
                return 1'b0;
            if (pat[62:52] == 11'd0)
            begin
                // Subnormal input: renormalize around its leading one.
                top = 51;
                while (top > 0 && mant[top] == 1'b0)
                    top--;
                frac = (mant << (52 - top)) & FRAC_MASK;
                expo = longint'(top) - 1074;
            end
            else
            begin
                frac = mant;
                expo = longint'(pat[62:52]) - 1023;
            end
            hi  = frac >> shift;
            lo  = frac & ((64'd1 << shift) - 64'd1);
            sig = hi + (((lo << (fbits + 1)) + frac) >> 53);
            if ((sig >> fbits) != 64'd0)
                return 1'b0;
            biased = expo + (longint'(1) << (ebits - 1)) - 1;
            if (biased < 0 || biased > (longint'(1) << ebits) - 1)
                return 1'b0;
            word = (64'(pat[63]) << (width - 1)) | (64'(biased) << fbits) | sig;
            return 1'b1;
        end
    endfunction

    // Byte count of a field type; zero for codes the block drops.
    function automatic int field_bytes(input logic [3:0] op);
        case (op)
            OP_S8, OP_U8:           return 1;
            OP_S16, OP_U16, OP_F16: return 2;
            OP_S32, OP_U32, OP_F32: return 4;
            OP_S64, OP_U64, OP_F64: return 8;
            default:                return 0;
        endcase
    endfunction

    // Queues the bytes of a packed word in transmit order.
    task automatic queue_word(input logic [63:0] word, input int nbytes, input logic le,
                              input logic err);
        byte_exp_t b;
        int pos;
        for (int k = 0; k < nbytes; k++)
        begin
            pos    = le ? k : nbytes - 1 - k;
            b.data = word[8*pos +: 8];
            b.last = (k == nbytes - 1);
            b.err  = err;
            pending_bytes.push_back(b);
        end
    endtask

    // Works out the packed word of a field and queues its bytes.
    task automatic predict_field(input logic [3:0] op, input logic le, input logic [63:0] value);
        logic [63:0] word;
        bit ok;
        begin
            ok = 1'b1;
            word = value;
            case (op)
                OP_F16:  ok = narrow_to_word(value, 16, 5, word);
                OP_F32:  ok = narrow_to_word(value, 32, 8, word);
                OP_F64:  ok = narrow_to_word(value, 64, 11, word);
                default: ;
            endcase
            queue_word(ok ? word : 64'd0, field_bytes(op), le, !ok);
        end
    endtask

    // Offers one field on s_axis and waits for its transaction.
    task automatic offer_field(input logic [3:0] op, input logic le, input logic [63:0] value);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {7'b000_0000, value, le};
        s_axis_tuser  = op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        fields_sent++;
    endtask

    // Drops s_axis_tvalid at the next falling edge so no field is offered while waiting.
    task automatic idle_input();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Draws a binary64 pattern that mostly lands inside the narrower formats.
    function automatic logic [63:0] random_float();
        logic [63:0] pat;
        int pick;
        begin
            pat  = {$urandom, $urandom};
            pick = $urandom_range(99);
            if (pick < 60)
                pat[62:52] = 11'(1023 + $urandom_range(40) - 20);
            else if (pick < 70)
                pat[62:52] = 11'(1023 + $urandom_range(300) - 150);
            else if (pick < 75)
                pat[62:52] = 11'h7FF;
            else if (pick < 80)
                pat[62:52] = 11'd0;
            else if (pick < 85)
                pat[51:0] = ($urandom_range(1) != 0) ? 52'd0 : '1;
            return pat;
        end
    endfunction

    // Receiver: random stalls, plus a long hold-off on request.
    initial
    begin
        m_axis_tready = 1'b0;
        hold_cnt = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && hold_cnt == 0)
                hold_cnt = HOLD_CYCLES;
            if (hold_cnt > 0)
            begin
                m_axis_tready = 1'b0;
                hold_cnt--;
                if (hold_cnt == 0)
                    hold_req = 1'b0;
            end
            else
            begin
                m_axis_tready = ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Output checker and watchdog.
    always @(posedge clk)
    begin
        byte_exp_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                bytes_seen++;
                if (m_axis_tuser)
                    range_errs_seen++;
                if (pending_bytes.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected byte %h last %b err %b", $time, m_axis_tdata,
                             m_axis_tlast, m_axis_tuser);
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (m_axis_tdata !== want.data)
                    begin
                        errors++;
                        $display("%0t: byte expected %h actual %h", $time, want.data,
                                 m_axis_tdata);
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        errors++;
                        $display("%0t: tlast expected %b actual %b", $time, want.last,
                                 m_axis_tlast);
                    end
                    if (m_axis_tuser !== want.err)
                    begin
                        errors++;
                        $display("%0t: range_error expected %b actual %b", $time, want.err,
                                 m_axis_tuser);
                    end
                end
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("typed_field_serializer regression: fail");
                $finish;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        row_t rows[$];
        row_t r;
        logic [3:0] op;
        logic le;
        logic [63:0] value;
        int drain;

        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b0;
        errors = 0;
        fields_sent = 0;
        bytes_seen = 0;
        range_errs_seen = 0;
        quiet_cycles = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: integer extremes, both byte orders, float specials and limits.
        rows = '{
            '{OP_S8,  1'b0, 64'hFFFF_FFFF_FFFF_FF80, 1, 64'h80, 1'b0},
            '{OP_U8,  1'b1, 64'h0000_0000_0000_00FF, 1, 64'hFF, 1'b0},
            '{OP_S16, 1'b0, 64'h0000_0000_0000_1234, 1, 64'h1234, 1'b0},
            '{OP_U16, 1'b1, 64'hFFFF_FFFF_FFFF_ABCD, 1, 64'hABCD, 1'b0},
            '{OP_S32, 1'b0, 64'h0000_0000_8000_0000, 1, 64'h8000_0000, 1'b0},
            '{OP_U32, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0},
            '{OP_S64, 1'b0, 64'h0102_0304_0506_0708, 1, 64'h0102_0304_0506_0708, 1'b0},
            '{OP_U64, 1'b1, 64'h0102_0304_0506_0708, 1, 64'h0102_0304_0506_0708, 1'b0},
            '{OP_U64, 1'b0, 64'h0000_0000_0000_0000, 1, 64'h0, 1'b0},
            '{OP_F16, 1'b0, 64'h3FF0_0000_0000_0000, 1, 64'h3C00, 1'b0},
            '{OP_F32, 1'b1, 64'h3FF0_0000_0000_0000, 1, 64'h3F80_0000, 1'b0},
            '{OP_F64, 1'b0, 64'hBFF0_0000_0000_0000, 1, 64'hBFF0_0000_0000_0000, 1'b0},
            '{OP_F32, 1'b0, 64'h0000_0000_0000_0000, 1, 64'h0, 1'b0},
            '{OP_F16, 1'b1, 64'h8000_0000_0000_0000, 1, 64'h0, 1'b0},
            '{OP_F16, 1'b0, 64'h7FF0_0000_0000_0000, 1, 64'h0, 1'b1},
            '{OP_F32, 1'b0, 64'h7FF8_0000_0000_0001, 1, 64'h0, 1'b1},
            '{OP_F64, 1'b1, 64'hFFF0_0000_0000_0000, 1, 64'h0, 1'b1},
            '{OP_F16, 1'b0, 64'h40EF_FC00_0000_0000, 0, 64'h0, 1'b0},
            '{OP_F16, 1'b0, 64'h4202_A05F_2000_0000, 0, 64'h0, 1'b0},
            '{OP_F16, 1'b1, 64'h3DDB_7CDF_D9D7_BDBB, 0, 64'h0, 1'b0},
            '{OP_F16, 1'b0, 64'h3FFF_FFFF_FFFF_FFFF, 0, 64'h0, 1'b0},
            '{OP_F64, 1'b0, 64'h0000_0000_0000_0001, 0, 64'h0, 1'b0},
            '{OP_F32, 1'b1, 64'h000F_FFFF_FFFF_FFFF, 0, 64'h0, 1'b0},
            '{OP_F64, 1'b0, 64'h7FEF_FFFF_FFFF_FFFF, 0, 64'h0, 1'b0},
            '{4'd11,  1'b0, 64'h1234_5678_9ABC_DEF0, 0, 64'h0, 1'b0},
            '{4'd15,  1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 0, 64'h0, 1'b0}
        };
        foreach (rows[i])
        begin
            r = rows[i];
            offer_field(r.op, r.le, r.value);
            if (r.known)
                queue_word(r.word, field_bytes(r.op), r.le, r.err);
            else
                predict_field(r.op, r.le, r.value);
        end

        // Random fields over four idling phases.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 60; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 60; end
                default: begin idle_pct = 10; stall_pct = 10; end
            endcase
            for (int i = 0; i < 80; i++)
            begin
                // Fill the block against a long receiver hold-off once.
                if (phase == 0 && i == 20)
                    hold_req = 1'b1;
                // Let everything drain once before going on.
                if (phase == 1 && i == 40)
                begin
                    idle_input();
                    wait (pending_bytes.size() == 0);
                end
                if ($urandom_range(99) < 50)
                    op = 4'($urandom_range(7));
                else if ($urandom_range(99) < 95)
                    op = 4'($urandom_range(10, 8));
                else
                    op = 4'($urandom_range(15, 11));
                value = (op >= OP_F16 && op <= OP_F64) ? random_float() : {$urandom, $urandom};
                le = 1'($urandom_range(1));
                offer_field(op, le, value);
                predict_field(op, le, value);
            end
            idle_input();
            wait (pending_bytes.size() == 0);
        end

        @(negedge clk);
        s_axis_tvalid = 1'b0;
        drain = 0;
        while (pending_bytes.size() != 0 && drain < IDLE_LIMIT)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (pending_bytes.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected bytes never arrived", $time, pending_bytes.size());
        end

        $display("Covered %0d fields: all integer widths, f16/f32/f64 narrowing, both byte orders,",
                 fields_sent);
        $display("dropped codes and stalls; %0d bytes checked, %0d flagged as range errors.",
                 bytes_seen, range_errs_seen);
        if (errors == 0)
            $display("typed_field_serializer regression: pass");
        else
            $display("typed_field_serializer regression: fail");
        $finish;
    end

endmodule

>>> files.f
rtl/tfs_pkg.sv
rtl/tfs_convert.sv
rtl/tfs_emit.sv
rtl/typed_field_serializer.sv
test/typed_field_serializer_tb.sv
